FILE: design/cossim_pkg.sv
`timescale 1ns / 1ps
package cossim_pkg;

	localparam int ELEM_WIDTH  = 16;
	localparam int SIM_WIDTH   = 16;
	localparam int QUOT_BITS   = 15;
	localparam int MAX_DIM_DEF = 1024;

	typedef enum logic [2:0] {
		ST_ACC,
		ST_DRAIN,
		ST_LOAD,
		ST_MUL,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic mul_step;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_accept;
		logic zero_norm;
		logic out_busy;
	} status_t;

endpackage

FILE: design/cossim_if.sv
`timescale 1ns / 1ps
interface cossim_in_if;
	import cossim_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] elem_a;
	logic signed [ELEM_WIDTH-1:0] elem_b;
	logic                         last_element;

	modport source (output valid, elem_a, elem_b, last_element, input ready);
	modport sink   (input valid, elem_a, elem_b, last_element, output ready);
endinterface

interface cossim_out_if;
	import cossim_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [SIM_WIDTH-1:0] similarity;
	logic                        zero_norm;
	logic                        length_overflow;

	modport source (output valid, similarity, zero_norm, length_overflow, input ready);
	modport sink   (input valid, similarity, zero_norm, length_overflow, output ready);
endinterface

FILE: design/cossim_ctrl.sv
`timescale 1ns / 1ps
module cossim_ctrl #(
	parameter int MAX_DIM = cossim_pkg::MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cossim_pkg::status_t status,
	output cossim_pkg::cmd_t    cmd
);
	import cossim_pkg::*;

	localparam int DW  = 2 * ELEM_WIDTH + $clog2(MAX_DIM);
	localparam int NW  = DW - 1;
	localparam int STW = $clog2(NW);

	state_t           state_q, state_d;
	logic [STW-1:0]   cnt_q, cnt_d;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_ACC: begin
				cmd.in_ready = 1'b1;
				if (status.last_accept) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cnt_d    = '0;
				state_d  = status.zero_norm ? ST_WAIT : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == STW'(NW - 1)) begin
					cnt_d   = '0;
					state_d = ST_SQRT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == STW'(NW - 1)) begin
					cnt_d   = '0;
					state_d = ST_DIVI;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == STW'(QUOT_BITS - 1)) begin
					cnt_d   = '0;
					state_d = ST_WAIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_WAIT: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	// a last transfer always closes the input; it stays closed until the result enters the output register
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		status.last_accept |=> !cmd.in_ready)
		else $error("input open right after last transfer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= STW'(NW - 1))
		else $error("step counter out of range");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (cnt_q == '0))
		else $error("step counter busy while accumulating");
endmodule

FILE: design/cossim_dp.sv
`timescale 1ns / 1ps
module cossim_dp #(
	parameter int MAX_DIM = cossim_pkg::MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	cossim_in_if.sink           elems,
	cossim_out_if.source        result,
	input  cossim_pkg::cmd_t    cmd,
	output cossim_pkg::status_t status
);
	import cossim_pkg::*;

	localparam int EW  = ELEM_WIDTH;
	localparam int CW  = $clog2(MAX_DIM + 1);
	localparam int DW  = 2 * EW + $clog2(MAX_DIM);
	localparam int NW  = DW - 1;
	localparam int PW  = 2 * NW;
	localparam int SRW = NW + 3;

	logic                   accept;
	logic                   valid_s1, take_s1;
	logic signed [2*EW-1:0] ab_s1;
	logic [2*EW-1:0]        aa_s1, bb_s1;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic signed [DW-1:0]   dot_q;
	logic [NW-1:0]          na_q, nb_q;

	logic [PW-1:0]          mcand_q, prod_q;
	logic [NW-1:0]          mplier_q, root_q;
	logic [SRW-1:0]         srem_q, srem_n, trial;
	logic [DW-1:0]          mag_q, drem_q;
	logic [DW:0]            dshift, droot;
	logic                   neg_q, zero_q, sat_q;
	logic [QUOT_BITS-1:0]   q_q;
	logic [SIM_WIDTH-1:0]   qq, sim;

	logic                   out_valid_q;
	logic [SIM_WIDTH-1:0]   sim_q;
	logic                   zero_out_q, ovf_out_q;

	assign accept      = elems.valid & cmd.in_ready;
	assign elems.ready = cmd.in_ready;

	assign status.last_accept = accept & elems.last_element;
	assign status.zero_norm   = (na_q == '0) | (nb_q == '0);
	assign status.out_busy    = out_valid_q & ~result.ready;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ab_s1   <= elems.elem_a * elems.elem_b;
			aa_s1   <= $unsigned((2*EW)'(elems.elem_a) * (2*EW)'(elems.elem_a));
			bb_s1   <= $unsigned((2*EW)'(elems.elem_b) * (2*EW)'(elems.elem_b));
			take_s1 <= count_q < CW'(MAX_DIM);
		end
	end

	// accumulators, element count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.finish) begin
			dot_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (count_q < CW'(MAX_DIM)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (valid_s1 && take_s1) begin
				dot_q <= dot_q + DW'(ab_s1);
				na_q  <= na_q + NW'(aa_s1);
				nb_q  <= nb_q + NW'(bb_s1);
			end
		end
	end

	// square root step
	always_comb begin
		srem_n = {srem_q[NW:0], prod_q[PW-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
	end

	// division step
	always_comb begin
		dshift = {drem_q, 1'b0};
		droot  = (DW + 1)'(root_q);
	end

	// shift-add multiply, digit-by-digit root, restoring divide
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mcand_q  <= PW'(na_q);
			mplier_q <= nb_q;
			prod_q   <= '0;
			srem_q   <= '0;
			root_q   <= '0;
			neg_q    <= dot_q[DW-1];
			mag_q    <= dot_q[DW-1] ? DW'(-dot_q) : DW'(dot_q);
			zero_q   <= status.zero_norm;
			sat_q    <= 1'b0;
			q_q      <= '0;
		end
		if (cmd.mul_step) begin
			prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.sqrt_step) begin
			prod_q <= prod_q << 2;
			if (srem_n >= trial) begin
				srem_q <= srem_n - trial;
				root_q <= {root_q[NW-2:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				root_q <= {root_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			sat_q  <= mag_q >= DW'(root_q);
			drem_q <= mag_q;
			q_q    <= '0;
		end
		if (cmd.div_step) begin
			if (dshift >= droot) begin
				drem_q <= DW'(dshift - droot);
				q_q    <= {q_q[QUOT_BITS-2:0], 1'b1};
			end else begin
				drem_q <= DW'(dshift);
				q_q    <= {q_q[QUOT_BITS-2:0], 1'b0};
			end
		end
	end

	// sign and clamp
	always_comb begin
		qq = sat_q ? {1'b1, {(SIM_WIDTH-1){1'b0}}} : {1'b0, q_q};
		priority if (zero_q) sim = '0;
		else if (neg_q)      sim = -qq;
		else if (sat_q)      sim = {1'b0, {(SIM_WIDTH-1){1'b1}}};
		else                 sim = qq;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sim_q      <= sim;
			zero_out_q <= zero_q;
			ovf_out_q  <= ovf_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.similarity      = sim_q;
	assign result.zero_norm       = zero_out_q;
	assign result.length_overflow = ovf_out_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_DIM))
		else $error("element count beyond limit");

	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && zero_out_q) |-> (sim_q == '0))
		else $error("zero norm with nonzero similarity");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sat_q) |-> (drem_q < DW'(root_q)))
		else $error("divide remainder not below root");
endmodule

FILE: design/cosine_similarity.sv
`timescale 1ns / 1ps
// element pairs: one transfer per cycle while accumulating, product stage then accumulate
// after the last transfer the sums pass the bit-serial multiply and square root loops
// and the restoring divide, then enter the output register; zero norm skips all three
// input stays closed from the last transfer until the result enters the output register
// reset clears accumulators, count, overflow flag and output valid at once
module cosine_similarity #(
	parameter int MAX_DIM = cossim_pkg::MAX_DIM_DEF
) (
	input logic          clk,
	input logic          arst_n,
	cossim_in_if.sink    elems,
	cossim_out_if.source result
);
	import cossim_pkg::*;

	cmd_t    cmd;
	status_t status;

	cossim_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.cmd   (cmd)
	);

	cossim_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.elems (elems),
		.result(result),
		.cmd   (cmd),
		.status(status)
	);
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import cossim_pkg::*;

	localparam int MAX_DIM   = MAX_DIM_DEF;
	localparam int LATENCY   = 2 * (31 + $clog2(MAX_DIM)) + 19;
	localparam int WDOG_MAX  = 4000;
	localparam int RAND_ITEMS = 400;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] a;
		logic signed [ELEM_WIDTH-1:0] b;
		logic                         last;
	} pair_t;

	typedef struct packed {
		logic signed [SIM_WIDTH-1:0] sim;
		logic                        zero;
		logic                        ovf;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cossim_in_if  elems_if ();
	cossim_out_if result_if ();

	cosine_similarity #(.MAX_DIM(MAX_DIM)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elems  (elems_if.sink),
		.result (result_if.source)
	);

	always #4 clk = ~clk;

	pair_t  pending_pairs[$];
	score_t expected_scores[$];
	int     mismatches = 0;
	bit     stim_done = 1'b0;
	bit     calm = 1'b0;
	bit     hold_req = 1'b0;

	// running sums of the vector pair in flight
	logic signed [63:0] dot_sum;
	logic [63:0]        norm_a_sum, norm_b_sum;
	int                 pair_count;
	bit                 dropped;

	function automatic logic [63:0] isqrt_prod(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		logic [63:0]  r;
		logic [63:0]  t;
		p = x * y;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (128'(t) * 128'(t) <= p)
				r = t;
		end
		return r;
	endfunction

	// fold one accepted pair into the sums, return 1 with a score on last
	function automatic bit score_pair(input pair_t p, output score_t s);
		logic [63:0] root, mag, q;
		bit          neg;
		if (pair_count < MAX_DIM) begin
			dot_sum    += 64'(p.a) * 64'(p.b);
			norm_a_sum += 64'(64'(p.a) * 64'(p.a));
			norm_b_sum += 64'(64'(p.b) * 64'(p.b));
			pair_count++;
		end else
			dropped = 1'b1;
		if (!p.last)
			return 1'b0;
		s = '0;
		s.ovf = dropped;
		if (norm_a_sum == 0 || norm_b_sum == 0)
			s.zero = 1'b1;
		else begin
			root = isqrt_prod(norm_a_sum, norm_b_sum);
			neg  = dot_sum[63];
			mag  = neg ? -dot_sum : dot_sum;
			if (root == 0 || mag >= root)
				q = 32768;
			else
				q = (mag * 64'd32768) / root;
			if (neg)
				s.sim = -q[15:0];
			else
				s.sim = (q > 32767) ? 16'sd32767 : q[15:0];
		end
		dot_sum = 0;
		norm_a_sum = 0;
		norm_b_sum = 0;
		pair_count = 0;
		dropped = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic signed [15:0] rnd_elem(input int mode);
		case (mode)
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_vector(input int len, input int kind);
		pair_t p;
		int    ma, mb;
		ma = $urandom_range(0, 5);
		mb = $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			p.a = rnd_elem(ma);
			p.b = (kind == 1) ? p.a : (kind == 2) ? -p.a : rnd_elem(mb);
			if (kind == 3)
				p.a = '0;
			p.last = (i == len - 1);
			pending_pairs.push_back(p);
		end
	endtask

	task automatic p_accept(output score_t s);
		pair_t p;
		p.a = elems_if.elem_a;
		p.b = elems_if.elem_b;
		p.last = elems_if.last_element;
		if (score_pair(p, s))
			expected_scores.push_back(s);
	endtask

	// stimulus
	initial begin
		int items;
		dot_sum = 0;
		norm_a_sum = 0;
		norm_b_sum = 0;
		pair_count = 0;
		dropped = 1'b0;
		// directed: extremes, parallel, anti-parallel, zero norm, orthogonal
		pending_pairs.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1});
		pending_pairs.push_back('{16'sh8000, 16'sh8000, 1'b1});
		pending_pairs.push_back('{16'sh8000, 16'sh7FFF, 1'b1});
		pending_pairs.push_back('{16'sh7FFF, 16'sh8000, 1'b0});
		pending_pairs.push_back('{16'sh0001, 16'sh0001, 1'b1});
		pending_pairs.push_back('{16'sh0000, 16'sh1234, 1'b1});
		pending_pairs.push_back('{16'sh0100, 16'sh0000, 1'b1});
		pending_pairs.push_back('{16'sh0000, 16'sh0000, 1'b1});
		pending_pairs.push_back('{16'sh0003, 16'sh0004, 1'b0});
		pending_pairs.push_back('{16'sh0004, 16'shFFFD, 1'b1});
		pending_pairs.push_back('{16'sh5555, 16'shAAAA, 1'b0});
		pending_pairs.push_back('{16'shAAAA, 16'sh5555, 1'b1});
		push_vector(3, 1);
		push_vector(4, 2);
		push_vector(2, 3);
		// too many elements: overflow vector
		push_vector(MAX_DIM + 3, 0);
		items = 0;
		while (items < RAND_ITEMS) begin
			int len, kind;
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			kind = $urandom_range(0, 6);
			push_vector(len, kind > 3 ? 0 : kind);
			items += len;
		end
		// reset once
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pairs.size() == 0);
		stim_done = 1'b1;
	end

	// calm tail once most items are gone
	always @(posedge clk)
		if (pending_pairs.size() < 150)
			calm <= 1'b1;

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elems_if.valid        <= 1'b0;
			elems_if.elem_a       <= '0;
			elems_if.elem_b       <= '0;
			elems_if.last_element <= 1'b0;
		end else begin
			automatic bit moved = elems_if.valid && elems_if.ready;
			automatic score_t s;
			if (moved) begin
				p_accept(s);
			end
			if (!elems_if.valid || moved) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					elems_if.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					automatic pair_t p = pending_pairs.pop_front();
					elems_if.valid        <= 1'b1;
					elems_if.elem_a       <= p.a;
					elems_if.elem_b       <= p.b;
					elems_if.last_element <= p.last;
					if (!calm && $urandom_range(0, 9) == 0)
						src_gap <= $urandom_range(1, 8);
				end else
					elems_if.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off early in the run
	int hold_cnt = 0;
	always @(posedge clk)
		if (arst_n && !hold_req && hold_cnt == 0 && pending_pairs.size() < 1400
		    && pending_pairs.size() > 1300)
			hold_cnt <= 400;
		else if (hold_cnt > 1) begin
			hold_cnt <= hold_cnt - 1;
			hold_req <= 1'b1;
		end else if (hold_cnt == 1) begin
			hold_cnt <= -1;
			hold_req <= 1'b0;
		end

	// monitor and sink-side stall
	int snk_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_scores.size() == 0) begin
					$error("unexpected result: similarity %0d", result_if.similarity);
					mismatches++;
				end else begin
					automatic score_t e = expected_scores.pop_front();
					if (result_if.similarity !== e.sim) begin
						$error("similarity: expected %0d, actual %0d", e.sim,
						       result_if.similarity);
						mismatches++;
					end
					if (result_if.zero_norm !== e.zero) begin
						$error("zero_norm: expected %0b, actual %0b", e.zero,
						       result_if.zero_norm);
						mismatches++;
					end
					if (result_if.length_overflow !== e.ovf) begin
						$error("length_overflow: expected %0b, actual %0b", e.ovf,
						       result_if.length_overflow);
						mismatches++;
					end
				end
			end
			if (hold_req)
				result_if.ready <= 1'b0;
			else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					snk_gap <= $urandom_range(1, 8);
			end
		end
	end

	// watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((elems_if.valid && elems_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		@(posedge clk);
		while (elems_if.valid || expected_scores.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_scores.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
